// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the queue pair RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in every cycle in which ante holds.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cond holds in every cycle out of reset.
`define AST_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define AST_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define AST_ALWAYS(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hdl/nvqp_pkg.sv =====
// Types and codes shared by the NVMe I/O queue pair host block.
package nvqp_pkg;

	// Result kinds reported with every result transfer
	typedef enum logic [2:0] {
		KIND_ISSUED   = 3'd0,
		KIND_FULL     = 3'd1,
		KIND_NOT_DONE = 3'd2,
		KIND_DONE_OK  = 3'd3,
		KIND_DONE_ERR = 3'd4,
		KIND_ZERO     = 3'd5
	} nvqp_kind_t;

	// Command opcodes
	typedef enum logic [1:0] {
		OPC_NONE  = 2'd0,
		OPC_WRITE = 2'd1,
		OPC_READ  = 2'd2
	} nvqp_opc_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_BLOCK_SIZE_LOG2     = 3'd0,
		CFG_MAX_TRANSFER_BLOCKS = 3'd1,
		CFG_NAMESPACE_ID        = 3'd2,
		CFG_SQ_LAST_INDEX       = 3'd3,
		CFG_CQ_LAST_INDEX       = 3'd4
	} nvqp_cfg_idx_t;

	// Input request kinds
	localparam logic FUNC_SUBMIT   = 1'b0;
	localparam logic FUNC_COMPLETE = 1'b1;

	// Status of a pointer reduction unit
	typedef struct packed {
		logic busy;
		logic done;
	} nvqp_red_stat_t;

endpackage

// ===== hdl/nvqp_req_if.sv =====
// Request channel: submit requests and observed completion entries.
interface nvqp_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [63:0] buffer_address;
	logic [63:0] block_address;
	logic [15:0] block_count;
	logic        write_flag;
	logic        entry_phase;
	logic [15:0] entry_sq_head;
	logic [15:0] entry_status_word;

	modport source (
		output valid, func, buffer_address, block_address, block_count, write_flag,
			entry_phase, entry_sq_head, entry_status_word,
		input  ready
	);
	modport sink (
		input  valid, func, buffer_address, block_address, block_count, write_flag,
			entry_phase, entry_sq_head, entry_status_word,
		output ready
	);
endinterface

// ===== hdl/nvqp_rsp_if.sv =====
// Result channel: command fields, doorbells and completion outcome.
interface nvqp_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [1:0]  opcode;
	logic [15:0] command_id;
	logic [63:0] data_pointer;
	logic [63:0] start_lba;
	logic [31:0] count_dword;
	logic [15:0] sq_doorbell;
	logic [15:0] cq_doorbell;
	logic [16:0] transferred_count;

	modport source (
		output valid, result_kind, opcode, command_id, data_pointer, start_lba,
			count_dword, sq_doorbell, cq_doorbell, transferred_count,
		input  ready
	);
	modport sink (
		input  valid, result_kind, opcode, command_id, data_pointer, start_lba,
			count_dword, sq_doorbell, cq_doorbell, transferred_count,
		output ready
	);
endinterface

// ===== hdl/nvqp_mod_reduce.sv =====
// Bit-serial remainder unit that folds a queue pointer into the queue size.
module nvqp_mod_reduce
	import nvqp_pkg::*;
#(
	parameter int INDEX_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [INDEX_BITS-1:0] dividend,
	input  logic [INDEX_BITS:0]   divisor,
	output nvqp_red_stat_t        stat,
	output logic [INDEX_BITS-1:0] rem
);

	localparam int CNT_W = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [INDEX_BITS-1:0] dvd_q;
	logic [INDEX_BITS:0]   dsr_q;
	logic [INDEX_BITS-1:0] rem_q;
	logic [INDEX_BITS:0]   trial;
	logic [INDEX_BITS:0]   trial_sub;

	// Shift in the next dividend bit and subtract where it fits
	always_comb begin
		trial     = {rem_q, dvd_q[cnt_q]};
		trial_sub = trial - dsr_q;
	end

	// Sequence one dividend bit per cycle, most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(INDEX_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Hold operands and the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= dsr_q) begin
				rem_q <= trial_sub[INDEX_BITS-1:0];
			end else begin
				rem_q <= trial[INDEX_BITS-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

// ===== hdl/nvme_io_queue_pair_host.sv =====
// Top level of the NVMe I/O queue pair host: command build and queue pointer tracking.
//
// Usage:
//   req carries either a submit request (func 0) or the completion entry seen at the
//   CQ head (func 1). rsp returns exactly one result per request: the result kind,
//   the command fields when a command is issued, the SQ tail and CQ head doorbell
//   values after the request, and the transferred block count.
//   cfg_we/cfg_index/cfg_data write one configuration register per cycle; write only
//   while the block holds no request in flight, which the block does not enforce.
// Timing:
//   A request is registered in the input stage at its transfer, and its result is then
//   registered in the result register, which drives rsp.valid. One request is taken
//   per cycle in steady state while rsp.ready stays high and no pointer reduction
//   runs, a rate set by the single input and result stages.
//   A write to sq_last_index or cq_last_index starts a bit-serial remainder pass
//   that folds the current SQ tail and CQ head into the new queue sizes; req.ready
//   is low from that write until the folded pointers are loaded.
// Reset:
//   arst_n clears the pointers, the pending count and both stages, sets the
//   completion phase to one and loads the configuration reset values.
// Stall:
//   While rsp.ready is low the result register holds, and req.ready drops once
//   the input stage also holds a request.
module nvme_io_queue_pair_host
	import nvqp_pkg::*;
#(
	parameter int PAGE_BYTES = 4096,
	parameter int INDEX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	nvqp_req_if.sink    req,
	nvqp_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	`include "assert_macros.svh"

	localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
	localparam int PW        = PAGE_LOG2 + 1;
	localparam logic [INDEX_BITS-1:0] IDX_MASK = '1;

	// Configuration registers
	logic [3:0]  blk_log2_q;
	logic [16:0] max_xfer_q;
	logic [15:0] sq_last_q;
	logic [15:0] cq_last_q;

	// Queue state
	logic [INDEX_BITS-1:0] sub_tail_q;
	logic [INDEX_BITS-1:0] sub_head_q;
	logic [INDEX_BITS-1:0] comp_head_q;
	logic                  comp_phase_q;
	logic [16:0]           pending_q;
	logic [INDEX_BITS-1:0] sq_red_q;
	logic [INDEX_BITS-1:0] cq_red_q;
	logic                  start_q;

	// Input stage
	logic        v_s1;
	logic        func_s1;
	logic [63:0] buf_s1;
	logic [63:0] lba_s1;
	logic [15:0] count_s1;
	logic        wr_s1;
	logic        phase_s1;
	logic [15:0] qhd_s1;
	logic [15:0] sts_s1;

	// Result register
	logic        out_v_q;
	nvqp_kind_t  kind_q;
	nvqp_opc_t   opc_q;
	logic [15:0] cid_q;
	logic [63:0] dptr_q;
	logic [63:0] slba_q;
	logic [31:0] cdw_q;
	logic [15:0] sqdb_q;
	logic [15:0] cqdb_q;
	logic [16:0] xfer_q;

	// Reduction units
	nvqp_red_stat_t        sq_stat;
	nvqp_red_stat_t        cq_stat;
	logic [INDEX_BITS-1:0] sq_rem;
	logic [INDEX_BITS-1:0] cq_rem;

	// Combinational results
	logic                  busy;
	logic                  adv;
	logic [3:0]            lg_c;
	logic [PW-1:0]         page_blk;
	logic [PW-1:0]         page_off;
	logic [PW-1:0]         page_lim;
	logic [16:0]           max_eff;
	logic [16:0]           cnt_c;
	logic [16:0]           cnt_m1;
	logic [INDEX_BITS-1:0] sq_last_eff;
	logic [INDEX_BITS-1:0] cq_last_eff;
	logic [INDEX_BITS:0]   sq_size;
	logic [INDEX_BITS:0]   cq_size;
	logic [INDEX_BITS:0]   sq_inc;
	logic [INDEX_BITS:0]   cq_inc;
	logic [INDEX_BITS-1:0] sq_next;
	logic [INDEX_BITS-1:0] cq_next;

	nvqp_kind_t            r_kind;
	nvqp_opc_t             r_opc;
	logic [15:0]           r_cid;
	logic [63:0]           r_dptr;
	logic [63:0]           r_slba;
	logic [31:0]           r_cdw;
	logic [16:0]           r_xfer;
	logic [INDEX_BITS-1:0] nx_tail;
	logic [INDEX_BITS-1:0] nx_head;
	logic [INDEX_BITS-1:0] nx_chead;
	logic                  nx_phase;
	logic [16:0]           nx_pend;
	logic [INDEX_BITS-1:0] nx_sqred;
	logic [INDEX_BITS-1:0] nx_cqred;

	// Stall intake while a pointer reduction runs or is about to land
	assign busy = start_q | sq_stat.busy | sq_stat.done | cq_stat.busy | cq_stat.done;
	assign adv  = !out_v_q || rsp.ready;
	assign req.ready = (!v_s1 || adv) && !busy;

	// Queue sizes from the last index, cut to the index range
	always_comb begin
		sq_last_eff = (sq_last_q > 16'(IDX_MASK)) ? IDX_MASK : sq_last_q[INDEX_BITS-1:0];
		cq_last_eff = (cq_last_q > 16'(IDX_MASK)) ? IDX_MASK : cq_last_q[INDEX_BITS-1:0];
		sq_size     = {1'b0, sq_last_eff} + 1'b1;
		cq_size     = {1'b0, cq_last_eff} + 1'b1;
		sq_inc      = {1'b0, sq_red_q} + 1'b1;
		cq_inc      = {1'b0, cq_red_q} + 1'b1;
		sq_next     = (sq_inc == sq_size) ? '0 : sq_inc[INDEX_BITS-1:0];
		cq_next     = (cq_inc == cq_size) ? '0 : cq_inc[INDEX_BITS-1:0];
	end

	// Clamp the block count to the page end and the transfer limit
	always_comb begin
		case (blk_log2_q) inside
			[4'd0:4'd8]:   lg_c = 4'd9;
			[4'd13:4'd15]: lg_c = 4'd12;
			default:       lg_c = blk_log2_q;
		endcase
		page_blk = PW'(PAGE_BYTES) >> lg_c;
		page_off = {1'b0, buf_s1[PAGE_LOG2-1:0]} >> lg_c;
		page_lim = page_blk - page_off;
		if (page_lim == '0) begin
			page_lim = PW'(1);
		end
		max_eff = (max_xfer_q == '0) ? 17'd1 : max_xfer_q;
		cnt_c   = {1'b0, count_s1};
		if (cnt_c > 17'(page_lim)) begin
			cnt_c = 17'(page_lim);
		end
		if (cnt_c > max_eff) begin
			cnt_c = max_eff;
		end
		cnt_m1 = cnt_c - 1'b1;
	end

	// Build the result and the next queue state for the staged request
	always_comb begin
		r_kind   = KIND_ZERO;
		r_opc    = OPC_NONE;
		r_cid    = '0;
		r_dptr   = '0;
		r_slba   = '0;
		r_cdw    = '0;
		r_xfer   = '0;
		nx_tail  = sub_tail_q;
		nx_head  = sub_head_q;
		nx_chead = comp_head_q;
		nx_phase = comp_phase_q;
		nx_pend  = pending_q;
		nx_sqred = sq_red_q;
		nx_cqred = cq_red_q;
		if (func_s1 == FUNC_SUBMIT) begin
			if (count_s1 == '0) begin
				r_kind = KIND_ZERO;
			end else if (sq_next == sub_head_q) begin
				r_kind = KIND_FULL;
			end else begin
				r_kind   = KIND_ISSUED;
				r_opc    = wr_s1 ? OPC_WRITE : OPC_READ;
				r_cid    = 16'(sub_tail_q);
				r_dptr   = buf_s1;
				r_slba   = lba_s1;
				r_cdw    = {1'b1, 15'd0, cnt_m1[15:0]};
				r_xfer   = cnt_c;
				nx_tail  = sq_next;
				nx_sqred = sq_next;
				nx_pend  = cnt_c;
			end
		end else begin
			if (phase_s1 != comp_phase_q) begin
				r_kind = KIND_NOT_DONE;
			end else begin
				// Toggle the phase when the head wraps
				if (cq_next < comp_head_q) begin
					nx_phase = !comp_phase_q;
				end
				nx_chead = cq_next;
				nx_cqred = cq_next;
				nx_head  = qhd_s1[INDEX_BITS-1:0];
				if (sts_s1[8:1] != 8'd0) begin
					r_kind = KIND_DONE_ERR;
				end else begin
					r_kind = KIND_DONE_OK;
					r_xfer = pending_q;
				end
				nx_pend = '0;
			end
		end
	end

	// Configuration writes; the namespace id reaches no result field and is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_log2_q <= 4'd9;
			max_xfer_q <= 17'd65536;
			sq_last_q  <= 16'd63;
			cq_last_q  <= 16'd255;
			start_q    <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_BLOCK_SIZE_LOG2:     blk_log2_q <= cfg_data[3:0];
					CFG_MAX_TRANSFER_BLOCKS: max_xfer_q <= cfg_data[16:0];
					CFG_SQ_LAST_INDEX: begin
						sq_last_q <= cfg_data[15:0];
						start_q   <= 1'b1;
					end
					CFG_CQ_LAST_INDEX: begin
						cq_last_q <= cfg_data[15:0];
						start_q   <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// Fold the pointers into the new queue sizes
	nvqp_mod_reduce #(.INDEX_BITS(INDEX_BITS)) u_sq_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (sub_tail_q),
		.divisor  (sq_size),
		.stat     (sq_stat),
		.rem      (sq_rem)
	);

	nvqp_mod_reduce #(.INDEX_BITS(INDEX_BITS)) u_cq_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (comp_head_q),
		.divisor  (cq_size),
		.stat     (cq_stat),
		.rem      (cq_rem)
	);

	// Advance queue state as each request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_tail_q   <= '0;
			sub_head_q   <= '0;
			comp_head_q  <= '0;
			comp_phase_q <= 1'b1;
			pending_q    <= '0;
			sq_red_q     <= '0;
			cq_red_q     <= '0;
		end else begin
			if (v_s1 && adv) begin
				sub_tail_q   <= nx_tail;
				sub_head_q   <= nx_head;
				comp_head_q  <= nx_chead;
				comp_phase_q <= nx_phase;
				pending_q    <= nx_pend;
				sq_red_q     <= nx_sqred;
				cq_red_q     <= nx_cqred;
			end
			if (sq_stat.done) begin
				sq_red_q <= sq_rem;
			end
			if (cq_stat.done) begin
				cq_red_q <= cq_rem;
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= v_s1;
			end
		end
	end

	// Capture the request on transfer
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1  <= req.func;
			buf_s1   <= req.buffer_address;
			lba_s1   <= req.block_address;
			count_s1 <= req.block_count;
			wr_s1    <= req.write_flag;
			phase_s1 <= req.entry_phase;
			qhd_s1   <= req.entry_sq_head;
			sts_s1   <= req.entry_status_word;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			kind_q <= r_kind;
			opc_q  <= r_opc;
			cid_q  <= r_cid;
			dptr_q <= r_dptr;
			slba_q <= r_slba;
			cdw_q  <= r_cdw;
			sqdb_q <= 16'(nx_tail);
			cqdb_q <= 16'(nx_chead);
			xfer_q <= r_xfer;
		end
	end

	assign rsp.valid             = out_v_q;
	assign rsp.result_kind       = kind_q;
	assign rsp.opcode            = opc_q;
	assign rsp.command_id        = cid_q;
	assign rsp.data_pointer      = dptr_q;
	assign rsp.start_lba         = slba_q;
	assign rsp.count_dword       = cdw_q;
	assign rsp.sq_doorbell       = sqdb_q;
	assign rsp.cq_doorbell       = cqdb_q;
	assign rsp.transferred_count = xfer_q;

	// An issued command always carries a nonzero block count
	`AST_IMPLY(a_issue_has_count, clk, arst_n,
		rsp.valid && rsp.result_kind == KIND_ISSUED,
		rsp.count_dword[31] && rsp.transferred_count != 17'd0,
		"issued command without a block count")
	// Only issued commands carry an opcode and a count dword
	`AST_IMPLY(a_no_cmd_unless_issued, clk, arst_n,
		rsp.valid && rsp.result_kind != KIND_ISSUED,
		rsp.opcode == OPC_NONE && rsp.count_dword == 32'd0,
		"command fields set on a non-issued result")
	// Reduced pointer copies stay inside their queues whenever requests flow
	`AST_IMPLY(a_sq_red_bound, clk, arst_n, !busy, sq_red_q <= sq_last_eff,
		"SQ pointer copy outside queue")
	`AST_IMPLY(a_cq_red_bound, clk, arst_n, !busy, cq_red_q <= cq_last_eff,
		"CQ pointer copy outside queue")

endmodule
